/* design/rotor_angle_velocity_estimator_macros.svh */
// ----------------------------------------------------------------------------
// rotor_angle_velocity_estimator_macros.svh
// Assertion shorthands for the rotor angle/velocity estimator checkers.
// ----------------------------------------------------------------------------
`ifndef ROTOR_ANGLE_VELOCITY_ESTIMATOR_MACROS_SVH
`define ROTOR_ANGLE_VELOCITY_ESTIMATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define RAVE_ASSERT_IMP(lbl, ck, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is low
`define RAVE_ASSERT_NXT(lbl, ck, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/rave_pkg.sv */
// ----------------------------------------------------------------------------
// rave_pkg
// Widths, constants and shared types of the rotor angle/velocity estimator.
// ----------------------------------------------------------------------------
package rave_pkg;

	// Field widths
	localparam int OP_W   = 2;
	localparam int ANG_W  = 16;
	localparam int VEL_W  = 32;
	localparam int TIME_W = 64;
	localparam int GAP_W  = 20;
	localparam int AGE_W  = 32;

	// Operation codes
	localparam logic [OP_W-1:0] OP_SAMPLE  = 2'd0;
	localparam logic [OP_W-1:0] OP_PREDICT = 2'd1;
	localparam logic [OP_W-1:0] OP_INVAL   = 2'd2;

	// Bits retired per cycle by the serial units
	localparam int DIG = 2;

	// Serial divider: dividend/quotient shifter and divisor widths
	localparam int DIV_W     = 64;
	localparam int DVS_W     = 20;
	localparam int DIV_CNT_W = 6;
	// Magnitude width for the measured velocity and blend divides
	localparam int MEAS_W    = 36;

	localparam logic [DIV_CNT_W-1:0] DIV_IT_MEAS = DIV_CNT_W'(MEAS_W / DIG);
	localparam logic [DIV_CNT_W-1:0] DIV_IT_PRED = DIV_CNT_W'(DIV_W / DIG);

	// Serial multiplier
	localparam int MUL_W     = 32;
	localparam int MUL_CNT_W = 5;
	localparam logic [MUL_CNT_W-1:0] MUL_IT = MUL_CNT_W'(MUL_W / DIG);

	// Arithmetic constants
	localparam logic [DVS_W-1:0] US_PER_S   = 20'd1000000;
	localparam logic [DVS_W-1:0] BLEND_DEN  = 20'd20;
	localparam logic [ANG_W-1:0] HALF_TURN  = {1'b1, {(ANG_W-1){1'b0}}};
	localparam logic [VEL_W-1:0] VEL_MAX    = {1'b0, {(VEL_W-1){1'b1}}};
	localparam logic [VEL_W-1:0] VEL_MIN    = {1'b1, {(VEL_W-1){1'b0}}};
	localparam logic [MUL_W-1:0] SPAN_LIMIT = {1'b1, {(MUL_W-1){1'b0}}};

	// Divider command
	typedef struct packed {
		logic                 start;
		logic [DIV_CNT_W-1:0] iters;
	} rave_div_cmd_t;

endpackage

/* design/rave_if.sv */
// ----------------------------------------------------------------------------
// rave_if
// Valid/ready channels of the estimator: request in, result out.
// ----------------------------------------------------------------------------
interface rave_req_if;
	import rave_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [OP_W-1:0]          op;
	logic [ANG_W-1:0]         angle_in;
	logic signed [VEL_W-1:0]  velocity_in;
	logic signed [TIME_W-1:0] time_us;

	modport source (output valid, op, angle_in, velocity_in, time_us, input ready);
	modport sink   (input valid, op, angle_in, velocity_in, time_us, output ready);
endinterface

interface rave_res_if;
	import rave_pkg::*;

	logic                    valid;
	logic                    ready;
	logic                    ok;
	logic [ANG_W-1:0]        angle_out;
	logic signed [VEL_W-1:0] velocity_out;
	logic [AGE_W-1:0]        age_us;

	modport source (output valid, ok, angle_out, velocity_out, age_us, input ready);
	modport sink   (input valid, ok, angle_out, velocity_out, age_us, output ready);
endinterface

/* design/rotor_angle_velocity_estimator.sv */
// ----------------------------------------------------------------------------
// rotor_angle_velocity_estimator
// Tracks rotor angle and velocity from sensor samples and extrapolates the
// angle to a requested time.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                  moves on
//  req      in   op, angle_in, velocity_in, time_us       valid & ready
//  res      out  ok, angle_out, velocity_out, age_us      valid & ready
//  cfg      in   cfg_wdata -> max_gap_us                  cfg_we
//
//  One request at a time. Sample with velocity update: two divides in the
//  2-bit/cycle divider. Predict: a multiply, then a divide by 1e6. Other
//  requests use neither unit.
//  A finished result sits in the output register; the next request is taken
//  meanwhile, and a predict stalls only when it would overwrite it.
//  Async reset clears the estimate, the held sample and max_gap_us to 100000.
// ----------------------------------------------------------------------------
module rotor_angle_velocity_estimator (
	input  logic                         clk,
	input  logic                         arst_n,
	rave_req_if.sink                     req,
	rave_res_if.source                   res,
	input  logic                         cfg_we,
	input  logic [rave_pkg::GAP_W-1:0]   cfg_wdata
);
	import rave_pkg::*;

	localparam int SUM_W = MEAS_W + 1;

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_DEC     = 4'd1;
	localparam logic [3:0] S_COMMIT  = 4'd2;
	localparam logic [3:0] S_M_GO    = 4'd3;
	localparam logic [3:0] S_M_WAIT  = 4'd4;
	localparam logic [3:0] S_B_GO    = 4'd5;
	localparam logic [3:0] S_B_WAIT  = 4'd6;
	localparam logic [3:0] S_EST     = 4'd7;
	localparam logic [3:0] S_SPAN    = 4'd8;
	localparam logic [3:0] S_P_MGO   = 4'd9;
	localparam logic [3:0] S_P_MWAIT = 4'd10;
	localparam logic [3:0] S_P_DGO   = 4'd11;
	localparam logic [3:0] S_P_DWAIT = 4'd12;
	localparam logic [3:0] S_OUT     = 4'd13;

	logic [3:0] st_q, st_d;

	// Configuration and architectural state
	logic [GAP_W-1:0]         max_gap_q;
	logic [ANG_W-1:0]         held_ang_q;
	logic signed [VEL_W-1:0]  vel_est_q;
	logic signed [TIME_W-1:0] held_t_q;
	logic                     est_vld_q;

	// Captured request
	logic [OP_W-1:0]          op_q;
	logic [ANG_W-1:0]         ang_q;
	logic signed [VEL_W-1:0]  vel_q;
	logic signed [TIME_W-1:0] t_q;

	// Working registers
	logic [ANG_W-1:0]         absd_q;
	logic                     dneg_q;
	logic [DVS_W-1:0]         dt_q;
	logic signed [VEL_W-1:0]  m_q;
	logic                     sneg_q;
	logic signed [VEL_W-1:0]  blend_q;
	logic                     ge_q;
	logic                     refuse_q;
	logic [AGE_W-1:0]         age_q;
	logic [MUL_W-1:0]         smag_q;
	logic [MUL_W-1:0]         vm_q;
	logic                     pneg_q;

	// Output register
	logic                     out_vld_q;
	logic                     out_ok_q;
	logic [ANG_W-1:0]         out_ang_q;
	logic signed [VEL_W-1:0]  out_vel_q;
	logic [AGE_W-1:0]         out_age_q;
	logic                     out_free;

	// Serial units
	rave_div_cmd_t            div_cmd;
	logic [DIV_W-1:0]         div_dividend;
	logic [DVS_W-1:0]         div_divisor;
	logic                     div_busy;
	logic [DIV_W-1:0]         div_quot;
	logic                     mul_start;
	logic                     mul_busy;
	logic [2*MUL_W-1:0]       mul_prod;

	// Decode-stage terms
	logic                     t_pos, held_pos, t_gt, t_ge, gap_ok, upd, refuse;
	logic [TIME_W-1:0]        dt;
	logic [ANG_W-1:0]         dm, absd;
	logic                     dm_neg;

	// Divide-stage terms
	logic [MEAS_W-1:0]        mmag;
	logic signed [SUM_W-1:0]  m_ext, v_ext, sum, sum_neg;
	logic [MEAS_W-1:0]        sum_mag;
	logic [VEL_W-1:0]         m_sat, blend;
	logic                     q_sat;

	// Estimate update
	logic signed [VEL_W+1:0]  e_sum, e_adj;
	logic [VEL_W-1:0]         vel_new;

	// Prediction terms
	logic [TIME_W-1:0]        diff;
	logic                     diff_hi, span_big, vneg;
	logic [AGE_W-1:0]         age;
	logic [MUL_W-1:0]         smag, ve_u, vm;
	logic [ANG_W-1:0]         step, pred_ang;

	assign req.ready = (st_q == S_IDLE);
	assign out_free  = !out_vld_q || res.ready;

	// Sample/predict decision terms
	always_comb begin
		t_pos    = !t_q[TIME_W-1] && (t_q != '0);
		held_pos = !held_t_q[TIME_W-1] && (held_t_q != '0);
		t_gt     = (t_q > held_t_q);
		t_ge     = (t_q >= held_t_q);
		dt       = t_q - held_t_q;
		gap_ok   = (dt[TIME_W-1:GAP_W] == '0) && (dt[GAP_W-1:0] < max_gap_q);
		upd      = est_vld_q && held_pos && t_gt && gap_ok;
		refuse   = !est_vld_q || !held_pos || (t_q == '0);
		dm       = ang_q - held_ang_q;
		dm_neg   = (dm > HALF_TURN);
		absd     = dm_neg ? (~dm + 1'b1) : dm;
	end

	// Measured velocity, 7/20 blend and the estimate mix
	always_comb begin
		mmag    = {{(MEAS_W-ANG_W){1'b0}}, absd_q} * {{(MEAS_W-DVS_W){1'b0}}, US_PER_S};
		q_sat   = (div_quot[DIV_W-1:VEL_W-1] != '0);
		if (dneg_q) begin
			m_sat = q_sat ? VEL_MIN : (~div_quot[VEL_W-1:0] + 1'b1);
		end else begin
			m_sat = q_sat ? VEL_MAX : div_quot[VEL_W-1:0];
		end
		m_ext   = {{(SUM_W-VEL_W){m_q[VEL_W-1]}}, m_q};
		v_ext   = {{(SUM_W-VEL_W){vel_q[VEL_W-1]}}, vel_q};
		sum     = (m_ext <<< 3) - m_ext + (v_ext <<< 3) + (v_ext <<< 2) + v_ext;
		sum_neg = -sum;
		sum_mag = sum[SUM_W-1] ? sum_neg[MEAS_W-1:0] : sum[MEAS_W-1:0];
		blend   = sneg_q ? (~div_quot[VEL_W-1:0] + 1'b1) : div_quot[VEL_W-1:0];
		e_sum   = ({{2{blend_q[VEL_W-1]}}, blend_q} <<< 1)
			+ {{2{blend_q[VEL_W-1]}}, blend_q}
			+ {{2{vel_est_q[VEL_W-1]}}, vel_est_q};
		// divide by four, rounding toward zero
		e_adj   = e_sum + (e_sum[VEL_W+1] ? (VEL_W+2)'(3) : '0);
		vel_new = e_adj[VEL_W+1:2];
	end

	// Prediction span, age and angle step
	always_comb begin
		diff     = ge_q ? (t_q - held_t_q) : (held_t_q - t_q);
		diff_hi  = (diff[TIME_W-1:MUL_W] != '0);
		span_big = diff_hi || (diff[MUL_W-1] && (diff[MUL_W-2:0] != '0));
		age      = ge_q ? (diff_hi ? '1 : diff[AGE_W-1:0]) : '0;
		smag     = span_big ? SPAN_LIMIT : diff[MUL_W-1:0];
		ve_u     = vel_est_q;
		vneg     = ve_u[VEL_W-1];
		vm       = vneg ? (~ve_u + 1'b1) : ve_u;
		step     = div_quot[ANG_W-1:0];
		pred_ang = held_ang_q + (pneg_q ? (~step + 1'b1) : step);
	end

	// Divider operand select
	always_comb begin
		div_cmd.start = (st_q == S_M_GO) || (st_q == S_B_GO) || (st_q == S_P_DGO);
		unique case (st_q)
			S_M_GO: begin
				div_dividend  = {mmag, {(DIV_W-MEAS_W){1'b0}}};
				div_divisor   = dt_q;
				div_cmd.iters = DIV_IT_MEAS;
			end
			S_B_GO: begin
				div_dividend  = {sum_mag, {(DIV_W-MEAS_W){1'b0}}};
				div_divisor   = BLEND_DEN;
				div_cmd.iters = DIV_IT_MEAS;
			end
			default: begin
				div_dividend  = mul_prod;
				div_divisor   = US_PER_S;
				div_cmd.iters = DIV_IT_PRED;
			end
		endcase
	end

	assign mul_start = (st_q == S_P_MGO);

	rave_sdiv u_sdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (div_cmd),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.quot     (div_quot)
	);

	rave_smul u_smul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (vm_q),
		.b      (smag_q),
		.busy   (mul_busy),
		.prod   (mul_prod)
	);

	// Sequencer
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			S_IDLE:    if (req.valid) st_d = S_DEC;
			S_DEC: begin
				unique case (op_q)
					OP_SAMPLE: begin
						if (!t_pos)   st_d = S_IDLE;
						else if (upd) st_d = S_M_GO;
						else          st_d = S_COMMIT;
					end
					OP_PREDICT: st_d = refuse ? S_OUT : S_SPAN;
					OP_INVAL:   st_d = S_IDLE;
					default:    st_d = S_IDLE;
				endcase
			end
			S_COMMIT:  st_d = S_IDLE;
			S_M_GO:    st_d = S_M_WAIT;
			S_M_WAIT:  if (!div_busy) st_d = S_B_GO;
			S_B_GO:    st_d = S_B_WAIT;
			S_B_WAIT:  if (!div_busy) st_d = S_EST;
			S_EST:     st_d = S_IDLE;
			S_SPAN:    st_d = S_P_MGO;
			S_P_MGO:   st_d = S_P_MWAIT;
			S_P_MWAIT: if (!mul_busy) st_d = S_P_DGO;
			S_P_DGO:   st_d = S_P_DWAIT;
			S_P_DWAIT: if (!div_busy) st_d = S_OUT;
			S_OUT:     if (out_free) st_d = S_IDLE;
			default:   st_d = S_IDLE;
		endcase
	end

	// Control and estimator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= S_IDLE;
			max_gap_q  <= GAP_W'(100000);
			held_ang_q <= '0;
			vel_est_q  <= '0;
			held_t_q   <= '0;
			est_vld_q  <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cfg_we) begin
				max_gap_q <= cfg_wdata;
			end
			// invalidate drops the estimate, keeps the held sample
			if (st_q == S_DEC && op_q == OP_INVAL) begin
				est_vld_q <= 1'b0;
				vel_est_q <= '0;
			end
			// sample without velocity update
			if (st_q == S_COMMIT) begin
				if (!est_vld_q) begin
					vel_est_q <= vel_q;
				end
				held_ang_q <= ang_q;
				held_t_q   <= t_q;
				est_vld_q  <= 1'b1;
			end
			// sample with velocity update
			if (st_q == S_EST) begin
				vel_est_q  <= vel_new;
				held_ang_q <= ang_q;
				held_t_q   <= t_q;
				est_vld_q  <= 1'b1;
			end
			if (st_q == S_OUT && out_free) begin
				out_vld_q <= 1'b1;
			end else if (res.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Payload and working registers
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_q  <= req.op;
			ang_q <= req.angle_in;
			vel_q <= req.velocity_in;
			t_q   <= req.time_us;
		end
		if (st_q == S_DEC) begin
			absd_q   <= absd;
			dneg_q   <= dm_neg;
			dt_q     <= dt[DVS_W-1:0];
			ge_q     <= t_ge;
			refuse_q <= refuse;
		end
		if (st_q == S_M_WAIT && !div_busy) begin
			m_q <= m_sat;
		end
		if (st_q == S_B_GO) begin
			sneg_q <= sum[SUM_W-1];
		end
		if (st_q == S_B_WAIT && !div_busy) begin
			blend_q <= blend;
		end
		if (st_q == S_SPAN) begin
			age_q  <= age;
			smag_q <= smag;
			vm_q   <= vm;
			pneg_q <= vneg ^ !ge_q;
		end
		if (st_q == S_OUT && out_free) begin
			out_ok_q  <= !refuse_q;
			out_ang_q <= refuse_q ? '0 : pred_ang;
			out_vel_q <= refuse_q ? '0 : vel_est_q;
			out_age_q <= refuse_q ? '0 : age_q;
		end
	end

	assign res.valid        = out_vld_q;
	assign res.ok           = out_ok_q;
	assign res.angle_out    = out_ang_q;
	assign res.velocity_out = out_vel_q;
	assign res.age_us       = out_age_q;
endmodule

/* design/rave_sdiv.sv */
// ----------------------------------------------------------------------------
// rave_sdiv
// Serial restoring divider, two quotient bits per cycle. The dividend comes
// in left aligned; when busy falls the shifter holds the quotient.
// ----------------------------------------------------------------------------
module rave_sdiv (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rave_pkg::rave_div_cmd_t       cmd,
	input  logic [rave_pkg::DIV_W-1:0]    dividend,
	input  logic [rave_pkg::DVS_W-1:0]    divisor,
	output logic                          busy,
	output logic [rave_pkg::DIV_W-1:0]    quot
);
	import rave_pkg::*;

	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0]     sh_q, sh_d;
	logic [DVS_W-1:0]     rem_q, rem_d;
	logic [DVS_W-1:0]     dvs_q;

	assign busy = (cnt_q != '0);
	assign quot = sh_q;

	// DIG restoring steps: shift in a dividend bit, subtract if it fits
	always_comb begin
		logic [DVS_W:0] r2;
		logic           take;
		rem_d = rem_q;
		sh_d  = sh_q;
		for (int i = 0; i < DIG; i++) begin
			r2   = {rem_d, sh_d[DIV_W-1]};
			take = (r2 >= {1'b0, dvs_q});
			if (take) begin
				r2 = r2 - {1'b0, dvs_q};
			end
			rem_d = r2[DVS_W-1:0];
			sh_d  = {sh_d[DIV_W-2:0], take};
		end
	end

	// Iteration counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.start) begin
			cnt_q <= cmd.iters;
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Datapath shifters
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			sh_q  <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy) begin
			sh_q  <= sh_d;
			rem_q <= rem_d;
		end
	end
endmodule

/* design/rave_smul.sv */
// ----------------------------------------------------------------------------
// rave_smul
// Serial shift-add multiplier, two multiplier bits per cycle, unsigned.
// ----------------------------------------------------------------------------
module rave_smul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [rave_pkg::MUL_W-1:0]    a,
	input  logic [rave_pkg::MUL_W-1:0]    b,
	output logic                          busy,
	output logic [2*rave_pkg::MUL_W-1:0]  prod
);
	import rave_pkg::*;

	logic [MUL_CNT_W-1:0] cnt_q;
	logic [MUL_W-1:0]     a_q;
	logic [MUL_W-1:0]     hi_q, hi_d;
	logic [MUL_W-1:0]     lo_q, lo_d;

	assign busy = (cnt_q != '0);
	assign prod = {hi_q, lo_q};

	// DIG steps: add multiplicand on a set bit, shift the product right
	always_comb begin
		logic [MUL_W:0] s;
		hi_d = hi_q;
		lo_d = lo_q;
		for (int i = 0; i < DIG; i++) begin
			s    = {1'b0, hi_d} + (lo_d[0] ? {1'b0, a_q} : '0);
			hi_d = s[MUL_W:1];
			lo_d = {s[0], lo_d[MUL_W-1:1]};
		end
	end

	// Iteration counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= MUL_IT;
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Product shifter
	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= a;
			hi_q <= '0;
			lo_q <= b;
		end else if (busy) begin
			hi_q <= hi_d;
			lo_q <= lo_d;
		end
	end
endmodule

/* design/rave_chk.sv */
// ----------------------------------------------------------------------------
// rave_chk
// Port-level checks of the estimator, bound to the top level.
// ----------------------------------------------------------------------------
`include "rotor_angle_velocity_estimator_macros.svh"

module rave_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_ready,
	input logic                         res_valid,
	input logic                         res_ready,
	input logic                         res_ok,
	input logic [rave_pkg::ANG_W-1:0]   res_angle_out,
	input logic [rave_pkg::VEL_W-1:0]   res_velocity_out,
	input logic [rave_pkg::AGE_W-1:0]   res_age_us
);
	// stalled result holds
	`RAVE_ASSERT_NXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res_ok) && $stable(res_angle_out) && $stable(res_velocity_out) && $stable(res_age_us), "result changed while stalled")
	// one request in flight: ready drops after a request is taken
	`RAVE_ASSERT_NXT(a_one_req, clk, arst_n, req_valid && req_ready, !req_ready, "request taken while busy")
	// no result appears right after a request is taken
	`RAVE_ASSERT_NXT(a_no_early, clk, arst_n, req_valid && req_ready, !$rose(res_valid), "result too early")
	// a refused prediction carries zero fields
	`RAVE_ASSERT_IMP(a_refused_zero, clk, arst_n, res_valid && !res_ok, res_angle_out == '0 && res_velocity_out == '0 && res_age_us == '0, "refused result not zero")
endmodule

bind rotor_angle_velocity_estimator rave_chk u_rave_chk (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.res_valid        (res.valid),
	.res_ready        (res.ready),
	.res_ok           (res.ok),
	.res_angle_out    (res.angle_out),
	.res_velocity_out (res.velocity_out),
	.res_age_us       (res.age_us)
);

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the rotor angle/velocity estimator. Requests go in
// over the request channel with random idle bursts. An in-bench model tracks
// the held sample, the velocity estimate and the max-gap setting, and queues
// the forecast that each predict request must return. Returned forecasts are
// checked in order, field by field. Edge cases come first, then random sensor
// tracks under several max-gap settings, then a stream with no idling.
// ----------------------------------------------------------------------------
module testbench;
	import rave_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 80;
	localparam int TRACK_LEN     = 260;

	typedef struct packed {
		logic             ok;
		logic [ANG_W-1:0] angle;
		logic [VEL_W-1:0] velocity;
		logic [AGE_W-1:0] age;
	} forecast_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [GAP_W-1:0] cfg_wdata;

	rave_req_if req_ch ();
	rave_res_if res_ch ();

	rotor_angle_velocity_estimator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// Estimator model state
	logic [ANG_W-1:0]         est_angle;
	logic signed [VEL_W-1:0]  est_vel;
	logic signed [TIME_W-1:0] est_time;
	logic                     est_valid;
	logic [GAP_W-1:0]         gap_limit_us;

	forecast_t due_forecasts[$];

	// Stimulus track: a rotor turning at trk_rate
	longint           trk_time;
	logic [ANG_W-1:0] trk_angle;
	int               trk_rate;

	bit gaps_on = 1'b1;
	int n_requests = 0;
	int n_forecasts = 0;
	int n_settings = 0;
	int n_errors = 0;

	always #4 clk = ~clk;

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Model: apply one accepted request, queue a forecast for predicts
	function automatic void estimator_step(input logic [OP_W-1:0] op,
			input logic [ANG_W-1:0] ang, input logic signed [VEL_W-1:0] vel,
			input logic signed [TIME_W-1:0] t);
		logic [63:0]      step_us;
		logic [63:0]      diff;
		logic [63:0]      mag;
		logic [63:0]      quo;
		logic [63:0]      vmag;
		logic [63:0]      smag;
		logic [63:0]      adv;
		logic [ANG_W-1:0] dm;
		longint           d;
		longint           meas;
		longint           blend;
		longint           span;
		forecast_t        fc;
		case (op)
			OP_SAMPLE: begin
				if (t > 0) begin
					if (est_valid && est_time > 0 && t > est_time) begin
						step_us = t - est_time;
						if (step_us < {44'd0, gap_limit_us}) begin
							// wrapped step; exactly half a turn stays positive
							dm = ang - est_angle;
							d = longint'(dm);
							if (dm > HALF_TURN)
								d = d - 65536;
							mag = (d < 0 ? -d : d) * 64'd1000000;
							quo = mag / step_us;
							if (d < 0) begin
								if (quo >= 64'h8000_0000)
									meas = -64'sd2147483648;
								else
									meas = -longint'(quo);
							end else begin
								if (quo > 64'h7FFF_FFFF)
									meas = 64'sd2147483647;
								else
									meas = longint'(quo);
							end
							blend = (7 * meas + 13 * longint'(vel)) / 20;
							est_vel = VEL_W'((3 * blend + longint'(est_vel)) / 4);
						end
					end
					if (!est_valid)
						est_vel = vel;
					est_angle = ang;
					est_time = t;
					est_valid = 1'b1;
				end
			end
			OP_INVAL: begin
				est_valid = 1'b0;
				est_vel = '0;
			end
			OP_PREDICT: begin
				fc = '0;
				if (est_valid && est_time > 0 && t != 0) begin
					fc.ok = 1'b1;
					fc.velocity = est_vel;
					if (t >= est_time) begin
						diff = t - est_time;
						fc.age = (diff > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : diff[31:0];
						span = (diff > 64'h8000_0000) ? 64'sd2147483648 : longint'(diff);
					end else begin
						diff = est_time - t;
						fc.age = '0;
						span = (diff > 64'h8000_0000) ? -64'sd2147483648 : -longint'(diff);
					end
					// magnitude product, truncated toward zero, then signed
					vmag = (est_vel < 0) ? -longint'(est_vel) : longint'(est_vel);
					smag = (span < 0) ? -span : span;
					adv = (vmag * smag) / 64'd1000000;
					if ((est_vel < 0) != (span < 0))
						adv = -adv;
					fc.angle = est_angle + adv[ANG_W-1:0];
				end
				due_forecasts.push_back(fc);
			end
			default: begin
			end
		endcase
	endfunction

	// Send one request; returns at the edge where it is accepted
	task automatic push_request(input logic [OP_W-1:0] op, input logic [ANG_W-1:0] ang,
			input logic [VEL_W-1:0] vel, input logic [TIME_W-1:0] t);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.op          <= op;
		req_ch.angle_in    <= ang;
		req_ch.velocity_in <= vel;
		req_ch.time_us     <= t;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		estimator_step(op, ang, vel, t);
		n_requests++;
	endtask

	// Drop valid, wait for every forecast, then let the datapath drain
	task automatic settle();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (due_forecasts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_gap_limit(input logic [GAP_W-1:0] value);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		gap_limit_us = value;
		n_settings++;
	endtask

	// Mostly consistent samples and predicts along the track, plus noise
	task automatic drive_track(input int count);
		int                       done;
		int                       pick;
		logic [63:0]              dt;
		logic signed [TIME_W-1:0] t;
		logic [VEL_W-1:0]         v;
		done = 0;
		while (done < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 4) begin
				if ($urandom_range(0, 3) == 0)
					trk_rate = $urandom;
				else
					trk_rate = int'($urandom_range(0, 33554432)) - 16777216;
			end
			if (pick < 52) begin
				case ($urandom_range(0, 9))
					0: dt = 64'(gap_limit_us);
					1: dt = 64'(gap_limit_us) - 64'd1;
					2: dt = 64'($urandom_range(1, 3 * gap_limit_us));
					default: dt = 64'($urandom_range(1,
						(gap_limit_us > 1) ? gap_limit_us - 1 : 1));
				endcase
				trk_time += dt;
				trk_angle += ANG_W'((longint'(trk_rate) * longint'(dt)) / 1000000);
				trk_angle += ANG_W'($urandom_range(0, 8)) - ANG_W'(4);
				if ($urandom_range(0, 19) == 0)
					v = $urandom;
				else
					v = trk_rate + $urandom_range(0, 2000) - 1000;
				push_request(OP_SAMPLE, trk_angle, v, trk_time);
				done++;
			end else if (pick < 80) begin
				case ($urandom_range(0, 19))
					0: t = rand64();
					1: t = '0;
					2: t = trk_time - longint'($urandom_range(1, 100000));
					3: t = trk_time;
					default: t = trk_time + longint'($urandom_range(1, 200000));
				endcase
				push_request(OP_PREDICT, ANG_W'($urandom), $urandom, t);
				done++;
			end else if (pick < 84) begin
				push_request(OP_INVAL, ANG_W'($urandom), $urandom, rand64());
				done++;
			end else if (pick < 88) begin
				// unused code, ignored by the block
				push_request(OP_UNUSED, ANG_W'($urandom), $urandom, rand64());
			end else if (pick < 94) begin
				// non-positive sample time, ignored
				t = rand64();
				if (t > 0)
					t = -t;
				push_request(OP_SAMPLE, ANG_W'($urandom), $urandom, t);
			end else begin
				// sample at an arbitrary time; resync the track when usable
				t = rand64();
				push_request(OP_SAMPLE, ANG_W'($urandom), $urandom, t);
				if (t > 0) begin
					done++;
					if (t < 64'sh4000_0000_0000_0000)
						trk_time = t;
				end
			end
		end
	endtask

	// Refusals, ignored samples, wrap, saturation and span clamping
	task automatic test_edge_cases();
		push_request(OP_PREDICT, 16'h1111, 32'h1, 64'd1000);
		push_request(OP_SAMPLE, 16'd123, 32'd5, 64'd0);
		push_request(OP_SAMPLE, 16'd123, 32'd5, -64'sd5);
		push_request(OP_SAMPLE, 16'h0000, VEL_MAX, 64'd1000);
		push_request(OP_PREDICT, 16'h0, 32'h0, 64'd0);
		push_request(OP_PREDICT, 16'h0, 32'h0, 64'd1000 + (64'd1 << 40));
		push_request(OP_PREDICT, 16'h0, 32'h0, 64'h8000_0000_0000_0000);
		// half-turn step counts positive; one-microsecond steps saturate
		push_request(OP_SAMPLE, HALF_TURN, VEL_MIN, 64'd1001);
		push_request(OP_SAMPLE, 16'h0001, VEL_MIN, 64'd1002);
		push_request(OP_SAMPLE, 16'hFFFF, 32'd777, 64'd1002);
		push_request(OP_SAMPLE, 16'h2000, 32'd777, 64'd500);
		push_request(OP_SAMPLE, 16'h2100, 32'd777, 64'd100500);
		push_request(OP_SAMPLE, 16'h2400, -32'sd90000, 64'd200499);
		push_request(OP_PREDICT, 16'hFFFF, 32'hFFFF_FFFF, 64'd212844);
		push_request(OP_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		push_request(OP_INVAL, 16'h0, 32'h0, 64'd0);
		push_request(OP_PREDICT, 16'h0, 32'h0, 64'd300000);
		push_request(OP_SAMPLE, 16'hFFFF, 32'hFFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF);
		push_request(OP_PREDICT, 16'h0, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF);
		push_request(OP_PREDICT, 16'h0, 32'h0, 64'h7FFF_FFFF_FFFF_FFFF);
	endtask

	// Smallest and largest max-gap settings, at and just below the limit
	task automatic test_gap_extremes();
		write_gap_limit(20'd1);
		push_request(OP_SAMPLE, 16'h0000, 32'd65536, 64'd100);
		push_request(OP_SAMPLE, 16'h0010, 32'd65536, 64'd101);
		push_request(OP_PREDICT, 16'h0, 32'h0, 64'd200);
		write_gap_limit(20'd1000000);
		push_request(OP_SAMPLE, 16'h4000, 32'd20000, 64'd1000100);
		push_request(OP_SAMPLE, 16'h8000, 32'd20000, 64'd2000100);
		push_request(OP_PREDICT, 16'h0, 32'h0, 64'd2500100);
	endtask

	task automatic test_random_tracks();
		logic [GAP_W-1:0] gap_list[6];
		gap_list[0] = 20'd100000;
		gap_list[1] = GAP_W'($urandom_range(1, 1000000));
		gap_list[2] = 20'd1;
		gap_list[3] = 20'd1000000;
		gap_list[4] = GAP_W'($urandom_range(1, 5000));
		gap_list[5] = GAP_W'($urandom_range(1, 1000000));
		foreach (gap_list[i]) begin
			write_gap_limit(gap_list[i]);
			trk_rate = int'($urandom_range(0, 33554432)) - 16777216;
			trk_angle = ANG_W'($urandom);
			if (i % 2)
				trk_time = 64'sh3000_0000_0000_0000 + longint'($urandom);
			else
				trk_time = longint'($urandom_range(1, 1 << 30));
			drive_track(TRACK_LEN);
		end
	endtask

	// Closing stretch with both sides always ready
	task automatic test_steady_stream();
		gaps_on = 1'b0;
		drive_track(100);
	endtask

	// Result sink: ready in random bursts
	initial begin
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (gaps_on && $urandom_range(0, 2) == 0)
				res_ch.ready <= 1'b0;
			else
				res_ch.ready <= 1'b1;
			repeat ($urandom_range(0, 14)) @(posedge clk);
		end
	end

	// Check each returned forecast against the oldest queued one
	always @(posedge clk) begin : check_forecast
		forecast_t got;
		forecast_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got.ok = res_ch.ok;
			got.angle = res_ch.angle_out;
			got.velocity = res_ch.velocity_out;
			got.age = res_ch.age_us;
			if (due_forecasts.size() == 0) begin
				n_errors++;
				$display("%0t: unexpected result ok=%0d angle=%h vel=%0d age=%0d",
					$time, got.ok, got.angle, $signed(got.velocity), got.age);
			end else begin
				want = due_forecasts.pop_front();
				n_forecasts++;
				if (got.ok !== want.ok || got.angle !== want.angle ||
						got.velocity !== want.velocity || got.age !== want.age) begin
					n_errors++;
					$display("%0t: expected ok=%0d angle=%h vel=%0d age=%0d, got ok=%0d angle=%h vel=%0d age=%0d",
						$time, want.ok, want.angle, $signed(want.velocity), want.age,
						got.ok, got.angle, $signed(got.velocity), got.age);
				end
			end
		end
	end

	initial begin
		req_ch.valid       <= 1'b0;
		req_ch.op          <= OP_SAMPLE;
		req_ch.angle_in    <= '0;
		req_ch.velocity_in <= '0;
		req_ch.time_us     <= '0;
		cfg_we             <= 1'b0;
		cfg_wdata          <= '0;
		arst_n             <= 1'b0;
		// reset state of the model
		est_angle    = '0;
		est_vel      = '0;
		est_time     = '0;
		est_valid    = 1'b0;
		gap_limit_us = 20'd100000;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_edge_cases();
		test_gap_extremes();
		test_random_tracks();
		test_steady_stream();
		settle();
		$display("covered %0d requests, %0d forecasts checked, %0d max-gap settings",
			n_requests, n_forecasts, n_settings);
		$display("mismatches: %0d", n_errors);
		if (n_errors == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

	// Watchdog
	initial begin
		#8_000_000;
		$display("timeout with %0d forecasts outstanding", due_forecasts.size());
		$display("testbench: FAIL");
		$finish;
	end

endmodule
